/* hdl/assert_macros.svh */
// Assertion helpers used by the classifier core.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define ACG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold on the cycle after reset is seen.
`define ACG_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

/* hdl/acg_pkg.sv */
// ----------------------------------------------------------------------------
// acg_pkg
// Shared types, constants and the arctangent table for the arc gauge
// pixel classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acg_pkg;

    // CORDIC datapath width: 10-bit magnitude, 20-bit prescale, growth, sign
    localparam int CW       = 33;
    localparam int PRESCALE = 20;
    localparam int ATAN_N   = 24;

    // atan(2^-i) in units of 1e-12 degree
    localparam longint unsigned ATAN_PDEG [ATAN_N] = '{
        64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
        64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
        64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
        64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
        64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
        64'd54641513,       64'd27320757,       64'd13660378,       64'd6830189
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_RADIUS       = 3'd2,
        CFG_CHARGE_PCT   = 3'd3,
        CFG_CHARGE_KNOWN = 3'd4,
        CFG_TRACK_STROKE = 3'd5,
        CFG_ARC_STROKE   = 3'd6,
        CFG_DASH_DEGREES = 3'd7
    } t_cfg_idx;

    // Per-pixel sideband carried along the CORDIC cells
    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic [21:0]        d4;
        logic               up_neg;
        logic               right_neg;
        logic               ax_zero;
        logic               ay_zero;
    } t_side;

    // Per-pixel flags carried along the modulo cells
    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic               in_arc;
        logic               in_trk;
        logic               arc_hit;
    } t_flags;

    // One finished result word
    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic               draw;
        logic               on_arc;
    } t_result;

    // atan(2^-i) in degrees, rounded to frac fraction bits
    function automatic longint unsigned atan_step(int i, int frac);
        longint unsigned one;
        one = 64'd1 << frac;
        return (ATAN_PDEG[i] * one + 64'd500000000000) / 64'd1000000000000;
    endfunction

endpackage

/* hdl/acg_front.sv */
// ----------------------------------------------------------------------------
// acg_front
// Entry cell: folds the offset into the first quadrant, squares the
// distance and forms the screen coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acg_front (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [9:0]       i_dx,
    input  logic signed [9:0]       i_dy,
    input  logic [9:0]              i_center_x,
    input  logic [9:0]              i_center_y,
    output logic signed [acg_pkg::CW-1:0] o_x,
    output logic signed [acg_pkg::CW-1:0] o_y,
    output acg_pkg::t_side          o_side
);
    import acg_pkg::*;

    logic signed [10:0] up;
    logic signed [10:0] right;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic signed [19:0] sqx;
    logic signed [19:0] sqy;
    logic [20:0]        sum;
    t_side              side;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    t_side                r_side;

    // Fold into the first quadrant and square
    always_comb begin
        up    = -{i_dy[9], i_dy};
        right = {i_dx[9], i_dx};
        ax    = up[10] ? 10'(-up) : up[9:0];
        ay    = right[10] ? 10'(-right) : right[9:0];
        sqx   = i_dx * i_dx;
        sqy   = i_dy * i_dy;
        sum   = 21'(unsigned'(sqx)) + 21'(unsigned'(sqy));
        side.pixel_x   = signed'({2'b00, i_center_x} + {{2{i_dx[9]}}, i_dx});
        side.pixel_y   = signed'({2'b00, i_center_y} + {{2{i_dy[9]}}, i_dy});
        side.d4        = {sum[19:0], 2'b00};
        side.up_neg    = up[10];
        side.right_neg = i_dx[9];
        side.ax_zero   = (i_dy == 10'sd0);
        side.ay_zero   = (i_dx == 10'sd0);
    end

    // Hold on stall, load when the chain advances
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= signed'({{(CW-10-PRESCALE){1'b0}}, ax, {PRESCALE{1'b0}}});
            r_y    <= signed'({{(CW-10-PRESCALE){1'b0}}, ay, {PRESCALE{1'b0}}});
            r_side <= side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_side = r_side;

endmodule

/* hdl/acg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// acg_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift and angle step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acg_cordic_cell #(
    parameter int              SHIFT = 0,
    parameter int              ZW    = 18,
    parameter longint unsigned STEP  = 64'd11520
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [acg_pkg::CW-1:0] i_x,
    input  logic signed [acg_pkg::CW-1:0] i_y,
    input  logic signed [ZW-1:0]          i_z,
    input  acg_pkg::t_side                i_side,
    output logic signed [acg_pkg::CW-1:0] o_x,
    output logic signed [acg_pkg::CW-1:0] o_y,
    output logic signed [ZW-1:0]          o_z,
    output acg_pkg::t_side                o_side
);
    import acg_pkg::*;

    localparam logic signed [ZW-1:0] ZSTEP = ZW'(STEP);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 y_pos;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    // Rotate towards the x axis
    always_comb begin
        xs    = i_x >>> SHIFT;
        ys    = i_y >>> SHIFT;
        y_pos = !i_y[CW-1] && (i_y != '0);
        if (y_pos) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ZSTEP;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ZSTEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

/* hdl/acg_mod_cell.sv */
// ----------------------------------------------------------------------------
// acg_mod_cell
// One restoring step of angle modulo the dash period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acg_mod_cell #(
    parameter int SHIFT = 0,
    parameter int AW    = 17,
    parameter int MW    = 25
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_rem,
    input  logic [MW-1:0]    i_period,
    input  acg_pkg::t_flags  i_flags,
    output logic [AW-1:0]    o_rem,
    output acg_pkg::t_flags  o_flags
);
    import acg_pkg::*;

    logic [MW-1:0] cmp;
    logic [MW-1:0] rem_w;
    logic [AW-1:0] n_rem;

    logic [AW-1:0] r_rem;
    t_flags        r_flags;

    // Subtract the shifted period when it fits
    always_comb begin
        cmp   = i_period << SHIFT;
        rem_w = MW'(i_rem);
        n_rem = (rem_w >= cmp) ? AW'(rem_w - cmp) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_flags <= i_flags;
        end
    end

    assign o_rem   = r_rem;
    assign o_flags = r_flags;

endmodule

/* hdl/arc_gauge_pixel_classifier_core.sv */
// ----------------------------------------------------------------------------
// arc_gauge_pixel_classifier_core
// An accepted word goes through the entry cell, CORDIC cells, map register, modulo cells and output register.
// Throughput: one word per cycle while the skid entry is empty, set by the chain of CORDIC and modulo cells.
// Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_gauge_pixel_classifier_core #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [9:0]  i_dx,
    input  logic signed [9:0]  i_dy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [11:0] o_pixel_x,
    output logic signed [11:0] o_pixel_y,
    output logic               o_draw,
    output logic               o_on_arc
);
    import acg_pkg::*;
    `include "assert_macros.svh"

    localparam int S    = CORDIC_STAGES;
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int ZW   = F + 10;
    localparam int AW   = F + 9;
    localparam int MW   = F + 17;
    localparam int TW   = F + 17;
    localparam int MODN = 8;
    localparam int NV   = S + 2 + MODN;
    localparam int U    = 1 << F;
    localparam logic [AW-1:0] A90  = AW'(90 * U);
    localparam logic [AW-1:0] A180 = AW'(180 * U);
    localparam logic [AW-1:0] A360 = AW'(360 * U);

    // Configuration registers
    logic [9:0] r_center_x, r_center_y;
    logic [7:0] r_radius, r_dash;
    logic [6:0] r_pct, r_trk_stroke, r_arc_stroke;
    logic       r_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius     <= 8'd32;
            r_pct        <= '0;
            r_known      <= 1'b0;
            r_trk_stroke <= 7'd2;
            r_arc_stroke <= 7'd4;
            r_dash       <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:     r_center_x   <= i_cfg_data;
                CFG_CENTER_Y:     r_center_y   <= i_cfg_data;
                CFG_RADIUS:       r_radius     <= i_cfg_data[7:0];
                CFG_CHARGE_PCT:   r_pct        <= i_cfg_data[6:0];
                CFG_CHARGE_KNOWN: r_known      <= i_cfg_data[0];
                CFG_TRACK_STROKE: r_trk_stroke <= i_cfg_data[6:0];
                CFG_ARC_STROKE:   r_arc_stroke <= i_cfg_data[6:0];
                CFG_DASH_DEGREES: r_dash       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Derived band limits, arc threshold and dash period
    logic [8:0]    two_r;
    logic [6:0]    pct_sat;
    logic [15:0]   thr_deg;
    logic [19:0]   r_arc_out_sq, r_arc_in_sq, r_trk_out_sq, r_trk_in_sq;
    logic          r_arc_in_neg, r_trk_in_neg, r_dash_nz;
    logic [TW-1:0] r_thr;
    logic [MW-1:0] r_period, r_half;

    always_comb begin
        two_r   = {r_radius, 1'b0};
        pct_sat = (r_pct > 7'd100) ? 7'd100 : r_pct;
        thr_deg = 16'd360 * (16'd100 - 16'(pct_sat));
    end

    always_ff @(posedge i_clk) begin
        r_arc_in_neg <= 9'(r_arc_stroke) > two_r;
        r_trk_in_neg <= 9'(r_trk_stroke) > two_r;
        r_arc_out_sq <= 20'(10'(two_r) + 10'(r_arc_stroke)) * 20'(10'(two_r) + 10'(r_arc_stroke));
        r_trk_out_sq <= 20'(10'(two_r) + 10'(r_trk_stroke)) * 20'(10'(two_r) + 10'(r_trk_stroke));
        r_arc_in_sq  <= 20'(two_r - 9'(r_arc_stroke)) * 20'(two_r - 9'(r_arc_stroke));
        r_trk_in_sq  <= 20'(two_r - 9'(r_trk_stroke)) * 20'(two_r - 9'(r_trk_stroke));
        r_thr        <= TW'(thr_deg) << F;
        r_period     <= MW'(r_dash) << (F + 1);
        r_half       <= MW'(r_dash) << F;
        r_dash_nz    <= (r_dash != 8'd0);
    end

    // Chain advance: stall only when the skid entry is occupied
    logic          en;
    logic [NV-1:0] r_vld;
    logic          r_skid_vld;
    logic          r_out_vld;
    t_result       r_out, r_skid, tail;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_in_valid};
        end
    end

    // Entry cell
    logic signed [CW-1:0] w_x [0:S];
    logic signed [CW-1:0] w_y [0:S];
    logic signed [ZW-1:0] w_z [0:S];
    t_side                w_side [0:S];

    acg_front u_front (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dx       (i_dx),
        .i_dy       (i_dy),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_x        (w_x[0]),
        .o_y        (w_y[0]),
        .o_side     (w_side[0])
    );
    assign w_z[0] = '0;

    // CORDIC cells
    for (genvar g = 0; g < S; g++) begin : g_cordic
        acg_cordic_cell #(
            .SHIFT (g),
            .ZW    (ZW),
            .STEP  (atan_step(g, F))
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_z    (w_z[g]),
            .i_side (w_side[g]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_z    (w_z[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // Clamp, map to the quadrant and test the radial bands
    t_side         cs;
    logic [AW-1:0] zc, ang;
    logic          in_arc, in_trk;
    logic [AW-1:0] r_ang;
    t_flags        r_map;

    always_comb begin
        cs = w_side[S];
        if (w_z[S][ZW-1]) begin
            zc = '0;
        end else if (w_z[S] > signed'(ZW'(A90))) begin
            zc = A90;
        end else begin
            zc = w_z[S][AW-1:0];
        end
        if (cs.ay_zero) begin
            zc = '0;
        end else if (cs.ax_zero) begin
            zc = A90;
        end
        if (!cs.up_neg) begin
            ang = cs.right_neg ? A360 - zc : zc;
        end else begin
            ang = cs.right_neg ? A180 + zc : A180 - zc;
        end
        if (ang >= A360) begin
            ang = ang - A360;
        end
        if (cs.ax_zero && cs.ay_zero) begin
            ang = A180;
        end
        in_arc = (cs.d4 <= 22'(r_arc_out_sq)) && (r_arc_in_neg || cs.d4 >= 22'(r_arc_in_sq));
        in_trk = (cs.d4 <= 22'(r_trk_out_sq)) && (r_trk_in_neg || cs.d4 >= 22'(r_trk_in_sq));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang          <= ang;
            r_map.pixel_x  <= cs.pixel_x;
            r_map.pixel_y  <= cs.pixel_y;
            r_map.in_arc   <= in_arc;
            r_map.in_trk   <= in_trk;
            r_map.arc_hit  <= 1'b0;
        end
    end

    // Solid arc test alongside the first modulo step
    logic [AW-1:0] m_rem [0:MODN];
    t_flags        m_flg [0:MODN];

    always_comb begin
        m_rem[0]         = r_ang;
        m_flg[0]         = r_map;
        m_flg[0].arc_hit = r_map.in_arc && r_known
                           && (TW'(r_ang) * TW'(100) >= r_thr);
    end

    for (genvar k = 0; k < MODN; k++) begin : g_mod
        acg_mod_cell #(
            .SHIFT (MODN - 1 - k),
            .AW    (AW),
            .MW    (MW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_rem    (m_rem[k]),
            .i_period (r_period),
            .i_flags  (m_flg[k]),
            .o_rem    (m_rem[k+1]),
            .o_flags  (m_flg[k+1])
        );
    end

    // Final decision
    always_comb begin
        tail.pixel_x = m_flg[MODN].pixel_x;
        tail.pixel_y = m_flg[MODN].pixel_y;
        tail.on_arc  = m_flg[MODN].arc_hit;
        tail.draw    = m_flg[MODN].arc_hit
                       || (m_flg[MODN].in_arc && m_flg[MODN].in_trk && r_dash_nz
                           && (MW'(m_rem[MODN]) < r_half));
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_vld[NV-1];
            end
        end else if (r_vld[NV-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            r_out <= r_skid_vld ? r_skid : tail;
        end else if (r_vld[NV-1] && en) begin
            r_skid <= tail;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_x   = r_out.pixel_x;
    assign o_pixel_y   = r_out.pixel_y;
    assign o_draw      = r_out.draw;
    assign o_on_arc    = r_out.on_arc;

    // Checks
    `ACG_ASSERT_RST(a_rst_clear, !r_out_vld && !r_skid_vld, "valid flags not cleared by reset")
    `ACG_ASSERT_IMP(a_skid_behind_out, r_skid_vld, r_out_vld, "skid word without output word")
    `ACG_ASSERT_IMP(a_stall_only_full, !o_in_ready, o_out_valid, "input stalled with no result waiting")
    `ACG_ASSERT_IMP(a_arc_is_drawn, o_out_valid && o_on_arc, o_draw, "arc pixel not drawn")

endmodule
